/* src/tmb_pkg.sv */
// Shared types and constants for the timer bank.
// Entry record, per-entry update controls, opcodes and register layout.
// No dependencies.
`timescale 1ns / 1ps

package tmb_pkg;

  // Field widths fixed by the interface.
  localparam int VAL_W    = 16;
  localparam int IDX_IN_W = 4;
  localparam int OP_W     = 3;
  localparam int PERIOD_W = 8;

  // Width used to compare an entry position against the bank size (up to 256).
  localparam int CMP_W = 9;

  // Default bank size.
  localparam int NUM_TIMERS_DEF = 16;

  // Tick period after reset.
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd1;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
  localparam logic [OP_W-1:0] OP_START_UP   = 3'd1;
  localparam logic [OP_W-1:0] OP_START_DOWN = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP_UP    = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP_DOWN  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ       = 3'd5;

  // Register index of the tick period (byte address 4 * index).
  localparam logic REG_TICK_PERIOD = 1'b0;

  // One timer entry.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             active;
    logic             down;
  } entry_t;

  // Controls handed from the sequencer to the update unit.
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic                hit;
    logic [VAL_W-1:0]    load;
    logic [PERIOD_W-1:0] period;
  } upd_ctrl_t;

endpackage

/* src/timer_bank_up_down.sv */
// Top level of the timer bank: APB register, sequencer and the ring of cells.
// Depends on tmb_pkg, tmb_cell and tmb_update.
`timescale 1ns / 1ps

// Usage:
// A transaction is issued by holding start high with opcode, timer_index and
// load_value; it is taken at the clock edge where start is high and busy is
// low. The entries sit in a ring of NUM_TIMERS cells that rotates one place
// per cycle while busy; the single update unit at the wrap point sees every
// entry once, so each transaction takes a full rotation of the ring.
// The result (timer_count, timer_active, counts_down) is shown for exactly
// one cycle with done high, once the rotation is complete.
// busy drops in that same cycle, so a new transaction can be taken while the
// result is on the ports.
// The receiver cannot stall; a result not taken in its cycle is gone.
// tick_period (ms) is set over APB at byte address 0 and reads back on
// prdata; the user must write it only while the bank is idle (unchecked).
// Synchronous reset stops every timer at zero counting up, sets the tick
// period to 1 and leaves the block idle; no clearing pass is needed.

module timer_bank_up_down #(
  parameter int NUM_TIMERS = tmb_pkg::NUM_TIMERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Command channel.
  input  logic                          start,
  output logic                          busy,
  input  logic [tmb_pkg::OP_W-1:0]      opcode,
  input  logic [tmb_pkg::IDX_IN_W-1:0]  timer_index,
  input  logic [tmb_pkg::VAL_W-1:0]     load_value,
  // Result channel.
  output logic                          done,
  output logic [tmb_pkg::VAL_W-1:0]     timer_count,
  output logic                          timer_active,
  output logic                          counts_down,
  // Register port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [tmb_pkg::PERIOD_W-1:0] tick_period;
  logic [IDX_W-1:0]             cnt;
  logic [tmb_pkg::OP_W-1:0]     op_q;
  logic [tmb_pkg::IDX_IN_W-1:0] idx_q;
  logic [tmb_pkg::VAL_W-1:0]    load_q;
  logic                         valid_q;
  tmb_pkg::entry_t              result;
  tmb_pkg::upd_ctrl_t           ctrl;
  tmb_pkg::entry_t              chain [NUM_TIMERS];
  tmb_pkg::entry_t              updated;
  logic                         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == tmb_pkg::REG_TICK_PERIOD);
  assign prdata  = reg_sel ? 32'(tick_period) : '0;

  // The tail cell holds the entry whose original position is cnt.
  assign ctrl.op     = op_q;
  assign ctrl.load   = load_q;
  assign ctrl.period = tick_period;
  assign ctrl.hit    = busy && valid_q &&
                       (tmb_pkg::CMP_W'(cnt) == tmb_pkg::CMP_W'(idx_q));

  tmb_update u_update (
    .ctrl      (ctrl),
    .entry_in  (chain[NUM_TIMERS-1]),
    .entry_out (updated)
  );

  // Ring of cells: cell 0 takes the updated tail entry, the rest their neighbor.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    if (i == 0) begin : g_head
      tmb_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (busy),
        .entry_in  (updated),
        .entry_out (chain[i])
      );
    end else begin : g_body
      tmb_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (busy),
        .entry_in  (chain[i-1]),
        .entry_out (chain[i])
      );
    end
  end

  // Sequencer and register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      done        <= 1'b0;
      cnt         <= '0;
      tick_period <= tmb_pkg::PERIOD_RESET;
    end else begin
      done <= 1'b0;
      if (psel && penable && pwrite && reg_sel) begin
        tick_period <= pwdata[tmb_pkg::PERIOD_W-1:0];
      end
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= IDX_W'(NUM_TIMERS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Transaction payload and captured result.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_q    <= opcode;
      idx_q   <= timer_index;
      load_q  <= load_value;
      valid_q <= tmb_pkg::CMP_W'(timer_index) < tmb_pkg::CMP_W'(NUM_TIMERS);
      result  <= '0;
    end else if (ctrl.hit) begin
      result <= updated;
    end
  end

  assign timer_count  = result.value;
  assign timer_active = result.active;
  assign counts_down  = result.down;

endmodule

/* src/tmb_cell.sv */
// One storage cell of the timer ring: holds a single timer entry.
// Takes its neighbor's entry on every shift cycle. Depends on tmb_pkg.
`timescale 1ns / 1ps

module tmb_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  tmb_pkg::entry_t entry_in,
  output tmb_pkg::entry_t entry_out
);

  tmb_pkg::entry_t entry;

  // Entry register; reset leaves the timer stopped at zero, counting up.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (shift) begin
      entry <= entry_in;
    end
  end

  assign entry_out = entry;

endmodule

/* src/tmb_update.sv */
// Update unit at the wrap point of the timer ring.
// Applies a tick to every passing entry or a command to the addressed one.
// Depends on tmb_pkg.
`timescale 1ns / 1ps

module tmb_update (
  input  tmb_pkg::upd_ctrl_t ctrl,
  input  tmb_pkg::entry_t    entry_in,
  output tmb_pkg::entry_t    entry_out
);

  logic [tmb_pkg::VAL_W-1:0] step;

  assign step = tmb_pkg::VAL_W'(ctrl.period);

  always_comb begin
    entry_out = entry_in;
    if (ctrl.op == tmb_pkg::OP_TICK) begin
      // A tick moves every running timer: up wraps, down stops at zero.
      if (entry_in.active) begin
        if (entry_in.down) begin
          if (entry_in.value >= step) begin
            entry_out.value = entry_in.value - step;
          end else begin
            entry_out.value = '0;
          end
        end else begin
          entry_out.value = entry_in.value + step;
        end
      end
    end else if (ctrl.hit) begin
      // Commands touch only the addressed entry; unused codes act as a read.
      unique case (ctrl.op)
        tmb_pkg::OP_START_UP: begin
          entry_out.value  = '0;
          entry_out.active = 1'b1;
          entry_out.down   = 1'b0;
        end
        tmb_pkg::OP_START_DOWN: begin
          entry_out.value  = ctrl.load;
          entry_out.active = 1'b1;
          entry_out.down   = 1'b1;
        end
        tmb_pkg::OP_STOP_UP: begin
          entry_out.value  = '0;
          entry_out.active = 1'b0;
          entry_out.down   = 1'b0;
        end
        tmb_pkg::OP_STOP_DOWN: begin
          entry_out.value  = tmb_pkg::VAL_W'(1);
          entry_out.active = 1'b0;
          entry_out.down   = 1'b1;
        end
        default: begin
          entry_out = entry_in;
        end
      endcase
    end
  end

endmodule
